// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, all sampled on the rising edge of clock
// and switched off while reset is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_CHECK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// A condition that must be followed by another one in the next cycle.
`define ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) else $error(msg);

`endif

// ----- design/mpmr_pkg.sv -----
// ----------------------------------------------------------------------------
// Message reassembler package
// Transaction types, status codes, register indexes and reset values shared
// by the reassembler modules.
// ----------------------------------------------------------------------------
package mpmr_pkg;

   // Default size of the message store in bytes.
   localparam int MPMR_BUF_BYTES = 4096;

   // Lengths and counts go up to 65536, so they need 17 bits.
   localparam int LEN_W = 17;
   // Store write addresses: a count plus an offset inside a packet.
   localparam int WADDR_W = 18;

   // Register indexes of the configuration port.
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_LENGTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COMMAND_TYPE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_MS    = 2'd2;

   // Register reset values.
   localparam logic [7:0]  HEADER_LENGTH_RST = 8'd3;
   localparam logic [7:0]  COMMAND_TYPE_RST  = 8'd0;
   localparam logic [31:0] TIMEOUT_MS_RST    = 32'd1000;

   // Result status codes.
   localparam logic [2:0] ST_HDR_OK    = 3'd0;
   localparam logic [2:0] ST_HDR_BAD   = 3'd1;
   localparam logic [2:0] ST_TOO_LARGE = 3'd2;
   localparam logic [2:0] ST_APPENDED  = 3'd3;
   localparam logic [2:0] ST_SIZE_ERR  = 3'd4;
   localparam logic [2:0] ST_COMPLETE  = 3'd5;
   localparam logic [2:0] ST_READ      = 3'd6;

   // Input transaction.
   typedef struct packed {
      logic        func;
      logic [7:0]  data;
      logic        last_byte;
      logic [31:0] now_ms;
      logic [15:0] read_addr;
   } req_type;

   // Result transaction.
   typedef struct packed {
      logic [2:0]  status;
      logic        timed_out;
      logic [15:0] message_length;
      logic [15:0] received_length;
      logic [7:0]  read_data;
   } rsp_type;

   // Configuration register values.
   typedef struct packed {
      logic [7:0]  header_length;
      logic [7:0]  command_type;
      logic [31:0] timeout_ms;
   } cfg_type;

   // Store write request from the parser.
   typedef struct packed {
      logic               en;
      logic [WADDR_W-1:0] addr;
      logic [7:0]         data;
   } mem_wr_type;

   // Result produced by the parser for one accepted transaction.
   typedef struct packed {
      logic    valid;
      logic    is_read;
      logic    read_ok;
      rsp_type rsp;
   } ctrl_res_type;

endpackage

// ----- design/multi_packet_message_reassembler_unit.sv -----
// ----------------------------------------------------------------------------
// Multi-packet message reassembler
// Collects packet bytes into a message store after a valid header packet,
// checks packet sizes and gaps, and reads message bytes back by address.
//
//   Channel   Direction  Handshake          Payload
//   req       in         req_valid/ready    req_data  (req_type)
//   rsp       out        rsp_valid/ready    rsp_data  (rsp_type)
//   csr       in         csr_we             csr_index, csr_wdata
//
// One transaction is taken per cycle while no result waits on rsp_ready;
// the parser and the store write port each handle one byte per cycle.
// A result appears in the cycle after its transaction; read data comes
// from the store's registered read port.
// Synchronous reset clears the message state; the store is not cleared.
// A waiting result blocks new transactions only while rsp_ready is low.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module multi_packet_message_reassembler_unit import mpmr_pkg::*; #(
   parameter int BUF_BYTES = MPMR_BUF_BYTES
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wdata
);

   localparam int ADDR_W = $clog2(BUF_BYTES);

   cfg_type      cfg_ff, cfg_in;
   logic         req_fire;
   logic         rd_en;
   mem_wr_type   mem_wr;
   ctrl_res_type res;
   logic [7:0]   ram_q;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_ff, rsp_in;
   logic         rd_sel_ff, rd_sel_in;

   // Configuration registers.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_HEADER_LENGTH: cfg_in.header_length = csr_wdata[7:0];
            CSR_COMMAND_TYPE:  cfg_in.command_type  = csr_wdata[7:0];
            CSR_TIMEOUT_MS:    cfg_in.timeout_ms    = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_length <= HEADER_LENGTH_RST;
         cfg_ff.command_type  <= COMMAND_TYPE_RST;
         cfg_ff.timeout_ms    <= TIMEOUT_MS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Input handshake.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign rd_en     = req_fire && req_data.func;

   mpmr_ctrl #(
      .BUF_BYTES (BUF_BYTES)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_fire (req_fire),
      .req      (req_data),
      .cfg      (cfg_ff),
      .mem_wr   (mem_wr),
      .res      (res)
   );

   mpmr_ram #(
      .WIDTH (8),
      .DEPTH (BUF_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr.en),
      .wr_addr (mem_wr.addr[ADDR_W-1:0]),
      .wr_data (mem_wr.data),
      .rd_en   (rd_en),
      .rd_addr (req_data.read_addr[ADDR_W-1:0]),
      .rd_data (ram_q)
   );

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      rd_sel_in    = rd_sel_ff;
      if (res.valid) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res.rsp;
         rd_sel_in    = res.is_read && res.read_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff    <= rsp_in;
      rd_sel_ff <= rd_sel_in;
   end

   // Read data joins the result from the store's read register.
   assign rsp_valid = rsp_valid_ff;
   always_comb begin
      rsp_data           = rsp_ff;
      rsp_data.read_data = rd_sel_ff ? ram_q : 8'd0;
   end

   // Reads and writes never share a cycle, every read yields a result, and
   // a result only follows an accepted transaction.
   `ASSERT_CHECK(a_rw_excl, !(mem_wr.en && rd_en), "store read and write together")
   `ASSERT_NEXT(a_read_rsp, rd_en, rsp_valid_ff, "read without result")
   `ASSERT_CHECK(a_rsp_source, $rose(rsp_valid_ff) |-> $past(req_fire), "result from nowhere")

endmodule

// ----- design/mpmr_ram.sv -----
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read output.
// ----------------------------------------------------------------------------
module mpmr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/mpmr_ctrl.sv -----
// ----------------------------------------------------------------------------
// Reassembler packet parser
// Tracks the packet and message state, decides where each byte goes in the
// store and builds the result for every packet end and every read.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mpmr_ctrl import mpmr_pkg::*; #(
   parameter int BUF_BYTES = MPMR_BUF_BYTES
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_fire,
   input  req_type      req,
   input  cfg_type      cfg,
   output mem_wr_type   mem_wr,
   output ctrl_res_type res
);

   localparam logic [LEN_W-1:0]   BUF_LEN  = LEN_W'(BUF_BYTES);
   localparam logic [WADDR_W-1:0] BUF_ADDR = WADDR_W'(BUF_BYTES);

   // Message and packet state.
   logic             recv_ff, recv_in;
   logic [7:0]       exp_ff, exp_in;
   logic [7:0]       limit_ff, limit_in;
   logic [7:0]       seen_ff, seen_in;
   logic [31:0]      last_ms_ff, last_ms_in;
   logic [LEN_W-1:0] decl_ff, decl_in;
   logic [LEN_W-1:0] stored_ff, stored_in;
   logic [8:0]       bip_ff, bip_in;
   logic [2:0][7:0]  hb_ff, hb_in;
   logic             pit_ff, pit_in;
   logic             pto_ff, pto_in;

   // Values as seen by the current byte.
   logic             first;
   logic [31:0]      gap;
   logic             to_now;
   logic             recv_e;
   logic [7:0]       exp_e, limit_e, seen_e;
   logic [LEN_W-1:0] decl_e, stored_e;
   logic             pit_e, pto_e;
   logic [2:0][7:0]  hb_e;
   logic [8:0]       len;
   logic             byte_op;
   logic [15:0]      prod;
   logic [LEN_W-1:0] hdr_len;
   logic             hdr_ok;
   logic [8:0]       seen_inc;
   logic [7:0]       seen_sat;
   logic             size_err;
   logic [LEN_W-1:0] stored_new;
   logic [WADDR_W-1:0] wr_addr;

   // Timeout check at the first byte of a packet; it clears the message.
   always_comb begin
      first    = (bip_ff == 9'd0);
      gap      = req.now_ms - last_ms_ff;
      to_now   = first && recv_ff && (gap > cfg.timeout_ms);
      recv_e   = to_now ? 1'b0 : recv_ff;
      exp_e    = to_now ? 8'd0 : exp_ff;
      limit_e  = to_now ? 8'd0 : limit_ff;
      seen_e   = to_now ? 8'd0 : seen_ff;
      decl_e   = to_now ? '0 : decl_ff;
      stored_e = to_now ? '0 : stored_ff;
      pit_e    = first ? !recv_e : pit_ff;
      pto_e    = first ? to_now : pto_ff;
      // Byte count saturates at 256.
      len      = bip_ff[8] ? bip_ff : bip_ff + 9'd1;
      byte_op  = req_fire && !req.func;
   end

   // The first three bytes of each packet are kept for header parsing.
   always_comb begin
      hb_e = hb_ff;
      if (bip_ff < 9'd3) begin
         hb_e[bip_ff[1:0]] = req.data;
      end
   end

   // Header and packet length arithmetic.
   always_comb begin
      prod       = 16'(hb_e[1]) * 16'(hb_e[2]);
      hdr_len    = LEN_W'(cfg.header_length) + LEN_W'(prod);
      hdr_ok     = (cfg.header_length >= 8'd3) && (len == {1'b0, cfg.header_length})
                   && (hb_e[0] == cfg.command_type);
      seen_inc   = {1'b0, seen_e} + 9'd1;
      seen_sat   = (seen_e == 8'hFF) ? seen_e : seen_inc[7:0];
      size_err   = (len > {1'b0, limit_e})
                   || ((len < {1'b0, limit_e}) && (seen_inc < {1'b0, exp_e}));
      stored_new = stored_e + LEN_W'(len);
   end

   // Store write: header candidates from address zero, payload behind the
   // bytes already stored; nothing past the packet size or the store.
   always_comb begin
      wr_addr     = pit_e ? WADDR_W'(bip_ff) : WADDR_W'(stored_e) + WADDR_W'(bip_ff);
      mem_wr.en   = byte_op && (pit_e || (bip_ff < {1'b0, limit_e})) && (wr_addr < BUF_ADDR);
      mem_wr.addr = wr_addr;
      mem_wr.data = req.data;
   end

   // Next state and result.
   always_comb begin
      recv_in    = recv_ff;
      exp_in     = exp_ff;
      limit_in   = limit_ff;
      seen_in    = seen_ff;
      last_ms_in = last_ms_ff;
      decl_in    = decl_ff;
      stored_in  = stored_ff;
      bip_in     = bip_ff;
      hb_in      = hb_ff;
      pit_in     = pit_ff;
      pto_in     = pto_ff;

      res                     = '0;
      res.read_ok             = ({2'b00, req.read_addr} < BUF_ADDR);
      res.rsp.timed_out       = pto_e;
      res.rsp.message_length  = decl_e[15:0];
      res.rsp.received_length = stored_e[15:0];

      if (req_fire && req.func) begin
         // A read leaves the state alone.
         res.valid               = 1'b1;
         res.is_read             = 1'b1;
         res.rsp.status          = ST_READ;
         res.rsp.timed_out       = 1'b0;
         res.rsp.message_length  = decl_ff[15:0];
         res.rsp.received_length = stored_ff[15:0];
      end else if (byte_op) begin
         recv_in   = recv_e;
         exp_in    = exp_e;
         limit_in  = limit_e;
         seen_in   = seen_e;
         decl_in   = decl_e;
         stored_in = stored_e;
         hb_in     = hb_e;
         pit_in    = pit_e;
         pto_in    = pto_e;
         bip_in    = len;

         if (req.last_byte) begin
            res.valid = 1'b1;
            bip_in    = 9'd0;
            pto_in    = 1'b0;
            if (pit_e) begin
               if (!hdr_ok) begin
                  res.rsp.status          = ST_HDR_BAD;
                  res.rsp.message_length  = '0;
                  res.rsp.received_length = '0;
               end else if (hdr_len > BUF_LEN) begin
                  res.rsp.status          = ST_TOO_LARGE;
                  res.rsp.message_length  = hdr_len[15:0];
                  res.rsp.received_length = '0;
               end else begin
                  recv_in    = (hb_e[1] != 8'd0);
                  exp_in     = hb_e[1];
                  limit_in   = hb_e[2];
                  seen_in    = 8'd0;
                  last_ms_in = req.now_ms;
                  decl_in    = hdr_len;
                  stored_in  = LEN_W'(cfg.header_length);
                  res.rsp.status          = (hb_e[1] == 8'd0) ? ST_COMPLETE : ST_HDR_OK;
                  res.rsp.message_length  = hdr_len[15:0];
                  res.rsp.received_length = {8'd0, cfg.header_length};
               end
            end else if (size_err) begin
               // Report the lengths, then drop the message.
               res.rsp.status = ST_SIZE_ERR;
               recv_in   = 1'b0;
               exp_in    = 8'd0;
               limit_in  = 8'd0;
               seen_in   = 8'd0;
               decl_in   = '0;
               stored_in = '0;
            end else begin
               stored_in  = stored_new;
               seen_in    = seen_sat;
               last_ms_in = req.now_ms;
               res.rsp.received_length = stored_new[15:0];
               if (seen_sat == exp_e) begin
                  recv_in        = 1'b0;
                  res.rsp.status = ST_COMPLETE;
               end else begin
                  res.rsp.status = ST_APPENDED;
               end
            end
         end
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         recv_ff    <= 1'b0;
         exp_ff     <= '0;
         limit_ff   <= '0;
         seen_ff    <= '0;
         last_ms_ff <= '0;
         decl_ff    <= '0;
         stored_ff  <= '0;
         bip_ff     <= '0;
         hb_ff      <= '0;
         pit_ff     <= 1'b0;
         pto_ff     <= 1'b0;
      end else begin
         recv_ff    <= recv_in;
         exp_ff     <= exp_in;
         limit_ff   <= limit_in;
         seen_ff    <= seen_in;
         last_ms_ff <= last_ms_in;
         decl_ff    <= decl_in;
         stored_ff  <= stored_in;
         bip_ff     <= bip_in;
         hb_ff      <= hb_in;
         pit_ff     <= pit_in;
         pto_ff     <= pto_in;
      end
   end

   // A pending message never holds more than it declared, never declares
   // more than the store and always waits for at least one packet.
   `ASSERT_CHECK(a_bip_range, bip_ff <= 9'd256, "byte position beyond 256")
   `ASSERT_CHECK(a_stored_le_decl, !recv_ff || (stored_ff <= decl_ff), "stored past declared")
   `ASSERT_CHECK(a_decl_fits, !recv_ff || (decl_ff <= BUF_LEN), "declared length over store")
   `ASSERT_CHECK(a_exp_nonzero, !recv_ff || (exp_ff != 8'd0), "receiving with no packets")

endmodule

// ----- bench/tb_multi_packet_message_reassembler_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Message reassembler testbench
// Drives packet bytes and store reads through the request channel, predicts
// every result with an in-bench copy of the reassembly rules, and compares
// each returned transaction field by field. A directed opening covers headers,
// appends, completion, size errors, oversized headers and timeouts; random
// phases then run under several register settings with random gaps on the
// request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_multi_packet_message_reassembler_unit;
   import mpmr_pkg::*;

   localparam int STORE_BYTES = MPMR_BUF_BYTES;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_HEADER_LENGTH;
   logic [31:0]          csr_wdata = '0;

   multi_packet_message_reassembler_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // Register values as the block should hold them.
   logic [7:0]  cfg_hdr_len;
   logic [7:0]  cfg_cmd;
   logic [31:0] cfg_timeout;

   // Reassembly state as the block should hold it.
   logic        msg_open;
   logic [7:0]  pkt_total;
   logic [7:0]  pkt_size;
   logic [7:0]  pkt_done;
   logic [31:0] last_pkt_ms;
   logic [16:0] msg_len;
   logic [16:0] msg_fill;
   logic [8:0]  pkt_pos;
   logic [7:0]  hdr_byte [3];
   logic        pkt_is_hdr;
   logic        pkt_dropped;
   logic [7:0]  store_image [STORE_BYTES];
   bit          store_valid [STORE_BYTES];
   int          top_written = -1;

   // Transactions waiting to be driven and results still to arrive.
   req_type queued_requests [$];
   rsp_type pending_results [$];

   logic [31:0] tick;
   int          item_count = 0;
   int          accepted_count = 0;
   int          timing_fault_pct = 0;
   int          mismatch_count = 0;

   function automatic void post_result(logic [2:0] st, logic to, int unsigned ml,
                                       int unsigned rl, logic [7:0] rd);
      rsp_type r;
      r.status          = st;
      r.timed_out       = to;
      r.message_length  = 16'(ml);
      r.received_length = 16'(rl);
      r.read_data       = rd;
      pending_results.push_back(r);
   endfunction

   task automatic close_message();
      msg_open  = 1'b0;
      pkt_total = '0;
      pkt_size  = '0;
      pkt_done  = '0;
      msg_len   = '0;
      msg_fill  = '0;
   endtask

   // Advance the reassembly state by one transaction and record its result.
   task automatic reassemble_step(req_type t);
      logic [31:0] gap;
      int unsigned pos;
      int unsigned addr;
      int unsigned len;
      int unsigned decl;
      logic        to;
      if (t.func) begin
         post_result(ST_READ, 1'b0, msg_len, msg_fill,
                     (t.read_addr < STORE_BYTES) ? store_image[t.read_addr] : 8'h00);
      end else begin
         // The gap check is made only at the first byte of a packet.
         if (pkt_pos == 0) begin
            pkt_dropped = 1'b0;
            gap = t.now_ms - last_pkt_ms;
            if (msg_open && gap > cfg_timeout) begin
               close_message();
               pkt_dropped = 1'b1;
            end
            pkt_is_hdr = !msg_open;
         end
         pos = pkt_pos;
         if (pos < 3)
            hdr_byte[pos] = t.data;
         // Header candidates land at the start of the store.
         addr = pkt_is_hdr ? pos : msg_fill + pos;
         if ((pkt_is_hdr || pos < pkt_size) && addr < STORE_BYTES) begin
            store_image[addr] = t.data;
            store_valid[addr] = 1'b1;
            if (int'(addr) > top_written)
               top_written = int'(addr);
         end
         if (pkt_pos < 256)
            pkt_pos++;
         if (t.last_byte) begin
            len         = pkt_pos;
            pkt_pos     = '0;
            to          = pkt_dropped;
            pkt_dropped = 1'b0;
            if (pkt_is_hdr) begin
               if (cfg_hdr_len >= 3 && len == cfg_hdr_len && hdr_byte[0] == cfg_cmd) begin
                  decl = int'(cfg_hdr_len) + int'(hdr_byte[1]) * int'(hdr_byte[2]);
                  if (decl > STORE_BYTES) begin
                     post_result(ST_TOO_LARGE, to, decl, 0, 8'h00);
                  end else begin
                     msg_open    = 1'b1;
                     pkt_total   = hdr_byte[1];
                     pkt_size    = hdr_byte[2];
                     pkt_done    = '0;
                     last_pkt_ms = t.now_ms;
                     msg_len     = 17'(decl);
                     msg_fill    = 17'(cfg_hdr_len);
                     if (pkt_total == 0) begin
                        msg_open = 1'b0;
                        post_result(ST_COMPLETE, to, msg_len, msg_fill, 8'h00);
                     end else begin
                        post_result(ST_HDR_OK, to, msg_len, msg_fill, 8'h00);
                     end
                  end
               end else begin
                  post_result(ST_HDR_BAD, to, 0, 0, 8'h00);
               end
            end else if (len > pkt_size ||
                         (len < pkt_size && int'(pkt_done) + 1 < int'(pkt_total))) begin
               // The error result still carries the lengths of the dropped message.
               post_result(ST_SIZE_ERR, to, msg_len, msg_fill, 8'h00);
               close_message();
            end else begin
               msg_fill = msg_fill + 17'(len);
               if (pkt_done < 255)
                  pkt_done++;
               last_pkt_ms = t.now_ms;
               if (pkt_done == pkt_total) begin
                  msg_open = 1'b0;
                  post_result(ST_COMPLETE, to, msg_len, msg_fill, 8'h00);
               end else begin
                  post_result(ST_APPENDED, to, msg_len, msg_fill, 8'h00);
               end
            end
         end
      end
   endtask

   // Store addresses are read only once written, or beyond the store.
   function automatic logic [15:0] read_target();
      int a;
      if (top_written < 0 || $urandom_range(0, 7) == 0)
         return $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom_range(STORE_BYTES, 65535));
      repeat (16) begin
         a = $urandom_range(0, top_written);
         if (store_valid[a])
            return 16'(a);
      end
      return 16'hFFFF;
   endfunction

   // Start time of the next packet, now and then placed on or past the timeout.
   function automatic logic [31:0] next_start();
      int r;
      r = $urandom_range(0, 99);
      if (r < timing_fault_pct)
         return last_pkt_ms + cfg_timeout + 1 + $urandom_range(0, 3);
      if (r < 2 * timing_fault_pct)
         return last_pkt_ms + cfg_timeout;
      return tick + (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20));
   endfunction

   // Queue one transaction; its result is predicted in queue order.
   task automatic queue_item(logic func, logic [7:0] d, logic last, logic [15:0] a);
      req_type t;
      t.func      = func;
      t.data      = d;
      t.last_byte = last;
      t.now_ms    = tick;
      t.read_addr = a;
      reassemble_step(t);
      queued_requests.push_back(t);
      item_count++;
   endtask

   task automatic send_read();
      queue_item(1'b1, 8'($urandom), 1'($urandom_range(0, 1)), read_target());
   endtask

   // One packet; bytes past the third are random, reads may fall in between.
   task automatic send_packet(int len, logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                              logic [31:0] start);
      int         pos;
      logic [7:0] d;
      tick = start;
      for (pos = 0; pos < len; pos++) begin
         if ($urandom_range(0, 19) == 0)
            send_read();
         d = (pos == 0) ? b0 : (pos == 1) ? b1 : (pos == 2) ? b2 : 8'($urandom);
         queue_item(1'b0, d, pos == len - 1, 16'($urandom));
         tick += $urandom_range(0, 1);
      end
   endtask

   // A header and its data packets, with occasional faults.
   task automatic send_message();
      int         count;
      int         size;
      int         hlen;
      int         plen;
      int         p;
      int         r;
      bit         abandon;
      logic [7:0] b0;
      abandon = 1'b0;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         count = $urandom_range(0, 5);
         size  = $urandom_range(1, 8);
      end else if (r < 75) begin
         count = $urandom_range(1, 3);
         size  = $urandom_range(9, 40);
      end else if (r < 85) begin
         // Declared length just below, at or just past the store size.
         size  = $urandom_range(128, 255);
         count = (STORE_BYTES - int'(cfg_hdr_len)) / size + $urandom_range(0, 1);
         if (count > 255)
            count = 255;
         abandon = 1'b1;
      end else if (r < 92) begin
         count   = $urandom_range(0, 255);
         size    = $urandom_range(0, 255);
         abandon = 1'b1;
      end else begin
         count = 0;
         size  = $urandom_range(0, 255);
      end
      hlen = cfg_hdr_len;
      if ($urandom_range(0, 9) == 0)
         hlen = $urandom_range(0, 1) ? hlen + 1 : $urandom_range(1, 12);
      if (hlen < 1)
         hlen = $urandom_range(1, 5);
      b0 = ($urandom_range(0, 9) == 0) ? 8'($urandom) : cfg_cmd;
      send_packet(hlen, b0, 8'(count), 8'(size), next_start());
      if (!msg_open)
         return;
      // A one-byte packet ends the message, breaks it or, for a packet size of one, is appended.
      if (abandon) begin
         send_packet(1, 8'($urandom), 8'($urandom), 8'($urandom), next_start());
         return;
      end
      // Left pending on purpose; the next header meets an open message.
      if ($urandom_range(0, 19) == 0)
         return;
      for (p = 0; p < count; p++) begin
         plen = size;
         r = $urandom_range(0, 99);
         if (r < 5)
            plen = size + 1;
         else if (r < 9 && size > 1)
            plen = $urandom_range(1, size - 1);
         else if (p == count - 1 && $urandom_range(0, 1) == 1)
            plen = $urandom_range(1, size);
         send_packet(plen, 8'($urandom), 8'($urandom), 8'($urandom), next_start());
         if (!msg_open)
            break;
      end
   endtask

   // Stray packets, including ones past 256 bytes.
   task automatic send_noise();
      int len;
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(256, 260) : $urandom_range(1, 12);
      send_packet(len, $urandom_range(0, 1) ? cfg_cmd : 8'($urandom),
                  8'($urandom), 8'($urandom), next_start());
   endtask

   task automatic run_segment(int n);
      int first;
      int r;
      first = item_count;
      while (item_count - first < n) begin
         r = $urandom_range(0, 99);
         if (r < 80)
            send_message();
         else if (r < 92)
            send_noise();
         else
            send_read();
      end
   endtask

   // Wait until every queued transaction is taken and every result is back.
   task automatic drain();
      while (accepted_count != item_count || pending_results.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic apply_config(logic [7:0] hl, logic [7:0] cmd, logic [31:0] tmo);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_HEADER_LENGTH;
      csr_wdata <= 32'(hl);
      @(posedge clock);
      csr_index <= CSR_COMMAND_TYPE;
      csr_wdata <= 32'(cmd);
      @(posedge clock);
      csr_index <= CSR_TIMEOUT_MS;
      csr_wdata <= tmo;
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_hdr_len = hl;
      cfg_cmd     = cmd;
      cfg_timeout = tmo;
   endtask

   // Request driver: bursts of random length separated by random gaps.
   int burst_left = 0;
   int gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            accepted_count++;
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (queued_requests.size() != 0) begin
               req_data  <= queued_requests.pop_front();
               req_valid <= 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 40);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: checks each transaction and stalls in changing patterns.
   int      stall_mode = 0;
   int      mode_left = 0;
   rsp_type want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $write("%0t: result with nothing expected: st=%0d to=%0d",
                         $time, rsp_data.status, rsp_data.timed_out);
                  $display(" mlen=%0d rlen=%0d rd=%02h", rsp_data.message_length,
                           rsp_data.received_length, rsp_data.read_data);
               end
            end else begin
               want = pending_results.pop_front();
               if (rsp_data.status !== want.status || rsp_data.timed_out !== want.timed_out ||
                   rsp_data.message_length !== want.message_length ||
                   rsp_data.received_length !== want.received_length ||
                   rsp_data.read_data !== want.read_data) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $write("%0t: mismatch: expected st=%0d to=%0d mlen=%0d rlen=%0d rd=%02h,",
                            $time, want.status, want.timed_out, want.message_length,
                            want.received_length, want.read_data);
                     $display(" got st=%0d to=%0d mlen=%0d rlen=%0d rd=%02h",
                              rsp_data.status, rsp_data.timed_out,
                              rsp_data.message_length, rsp_data.received_length,
                              rsp_data.read_data);
                  end
               end
            end
         end
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(20, 200);
         end else begin
            mode_left--;
         end
         case (stall_mode)
            0: begin
               rsp_ready <= 1'b1;
            end
            1: begin
               rsp_ready <= ($urandom_range(0, 3) != 0);
            end
            2: begin
               rsp_ready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
               rsp_ready <= ~rsp_ready;
            end
         endcase
      end
   end

   // Stimulus and run control.
   initial begin
      cfg_hdr_len = HEADER_LENGTH_RST;
      cfg_cmd     = COMMAND_TYPE_RST;
      cfg_timeout = TIMEOUT_MS_RST;
      close_message();
      last_pkt_ms = '0;
      pkt_pos     = '0;
      hdr_byte    = '{default: 8'h00};
      pkt_is_hdr  = 1'b0;
      pkt_dropped = 1'b0;
      tick        = 32'd100;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed opening on the reset register values.
      // A two-packet message; reads fall inside the first data packet, and a
      // short last packet still completes the message.
      send_packet(3, 8'h00, 8'd2, 8'd2, tick + 5);
      tick += 3;
      queue_item(1'b0, 8'hAA, 1'b0, 16'h0000);
      queue_item(1'b1, 8'h00, 1'b0, 16'h0000);
      queue_item(1'b1, 8'hFF, 1'b1, 16'hFFFF);
      queue_item(1'b0, 8'h55, 1'b1, 16'hFFFF);
      send_packet(1, 8'hFF, 8'h00, 8'h00, tick + 2);
      // Zero packet count, wrong command byte, oversized declared length.
      send_packet(3, 8'h00, 8'd0, 8'd5, tick + 1);
      send_packet(3, 8'hFF, 8'd1, 8'd1, tick + 1);
      send_packet(3, 8'h00, 8'hFF, 8'hFF, tick + 1);
      // A data packet longer than the packet size.
      send_packet(3, 8'h00, 8'd1, 8'd2, tick + 1);
      send_packet(3, 8'h01, 8'h02, 8'h03, tick + 1);
      // A late packet drops the message and is taken as a new header.
      send_packet(3, 8'h00, 8'd2, 8'd1, tick + 1);
      send_packet(3, 8'h00, 8'd1, 8'd1, last_pkt_ms + cfg_timeout + 1);
      send_packet(1, 8'h77, 8'h00, 8'h00, tick + 1);
      drain();

      // Random phases; the sender pauses for all results halfway through the first.
      timing_fault_pct = 4;
      run_segment(130);
      drain();
      run_segment(120);
      drain();

      apply_config(8'd255, 8'd255, 32'hFFFF_FFFF);
      run_segment(250);
      drain();

      // Header length below three: no header is ever accepted.
      apply_config(8'd2, 8'h5A, 32'd5);
      run_segment(40);
      drain();

      // Zero timeout: any gap between packets drops the message.
      apply_config(8'($urandom_range(3, 12)), 8'($urandom), 32'd0);
      run_segment(180);
      drain();

      // Short timeout with the millisecond tick wrapping around.
      tick = 32'hFFFF_FF00;
      apply_config(8'($urandom_range(3, 8)), 8'($urandom), 32'($urandom_range(1, 100)));
      run_segment(180);
      drain();

      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("multi_packet_message_reassembler_unit regression: pass");
      else
         $display("multi_packet_message_reassembler_unit regression: fail");
      $finish;
   end

   // Watchdog.
   initial begin
      #5_000_000;
      $display("multi_packet_message_reassembler_unit regression: fail");
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+design
design/mpmr_pkg.sv
design/mpmr_ram.sv
design/mpmr_ctrl.sv
design/multi_packet_message_reassembler_unit.sv
bench/tb_multi_packet_message_reassembler_unit.sv
